// ===== hdl/g2j_pkg.sv =====
// ----------------------------------------------------------------------------
// g2j_pkg
// Types, register codes, table builder and saturation helpers for the
// two-dimensional gaussian model and jacobian block
// ----------------------------------------------------------------------------
package g2j_pkg;

	localparam int MAX_SIDE_DEF = 64;
	localparam int EXP_DEPTH_DEF = 256;
	localparam int CFG_W = 32;

	localparam logic [31:0] AMPLITUDE_RST = 32'h0001_0000;
	localparam logic [23:0] SIGMA_RST = 24'h01_0000;
	localparam logic [31:0] BACKGROUND_RST = 32'h0000_0000;
	localparam logic [23:0] CENTER_RST = 24'h01_0000;
	localparam logic [6:0] FRAME_SIDE_RST = 7'd4;
	localparam logic [16:0] ONE_Q16 = 17'h1_0000;

	typedef enum logic [2:0] {
		REG_AMPLITUDE = 3'd0,
		REG_SIGMA = 3'd1,
		REG_BACKGROUND = 3'd2,
		REG_CENTER_X = 3'd3,
		REG_CENTER_Y = 3'd4,
		REG_FRAME_SIDE = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [5:0] col;
		logic [5:0] row;
	} pix_word_t;

	typedef struct packed {
		logic [11:0] pixel_index;
		logic signed [31:0] model_value;
		logic [16:0] d_amplitude;
		logic signed [31:0] d_sigma;
		logic [16:0] d_background;
		logic signed [31:0] d_center_x;
		logic signed [31:0] d_center_y;
	} res_word_t;

	// per-pixel values carried alongside the arithmetic
	typedef struct packed {
		logic [11:0] idx;
		logic [23:0] adx;
		logic [23:0] ady;
		logic xneg;
		logic yneg;
		logic [19:0] t;
		logic [16:0] e;
		logic [31:0] model;
	} car_t;

	// elaboration-time shift-subtract division
	function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = (r << 1) | longint'(n[b]);
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-16/depth) in Q31 as a truncated taylor sum
	function automatic longint unsigned exp_base(int lg);
		longint term;
		longint base;
		term = longint'(1) << 31;
		base = term;
		for (int k = 1; k <= 24; k++) begin
			term = longint'(udiv(longint'(term * 16) >> lg, longint'(k)));
			base = (k % 2 == 1) ? base - term : base + term;
		end
		if (base < 0)
			base = 0;
		return longint'(base);
	endfunction

	function automatic logic [16:0] exp_entry(longint unsigned base, int idx);
		longint unsigned cur;
		longint unsigned q;
		cur = longint'(1) << 31;
		if (idx == 0)
			return ONE_Q16;
		for (int k = 1; k <= idx; k++)
			cur = (cur * base + (longint'(1) << 30)) >> 31;
		q = (cur + (longint'(1) << 14)) >> 15;
		if (q > 65535)
			q = 65535;
		return 17'(q);
	endfunction

	// signed magnitude to 32 bit signed with saturation
	function automatic logic [31:0] sat_mag(logic neg, logic ovf, logic [31:0] q);
		logic [31:0] r;
		if (neg)
			r = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
		else
			r = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
		return r;
	endfunction

endpackage

// ===== hdl/g2j_div.sv =====
// ----------------------------------------------------------------------------
// g2j_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// flag for quotients that do not fit and a side payload
// ----------------------------------------------------------------------------
module g2j_div #(
	parameter int NW = 64,
	parameter int DW = 48,
	parameter int QW = 20,
	parameter int PW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	input logic [PW-1:0] pay,
	output logic q_vld,
	output logic [QW-1:0] quot,
	output logic ovf,
	output logic [PW-1:0] q_pay
);

	localparam int TW = NW - QW;
	localparam int CW = (TW > DW) ? TW : DW;

	logic vld_s [QW+1];
	logic ovf_s [QW+1];
	logic [DW-1:0] rem_s [QW+1];
	logic [QW-1:0] nlo_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic [PW-1:0] pay_s [QW+1];
	logic [DW:0] trial [QW];
	logic ge [QW];
	logic [TW-1:0] top;

	assign top = num[NW-1:QW];

	always_comb begin
		for (int k = 0; k < QW; k++) begin
			trial[k] = {rem_s[k], nlo_s[k][QW-1]};
			ge[k] = trial[k] >= {1'b0, den};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld;
			for (int k = 1; k <= QW; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(top);
			nlo_s[0] <= num[QW-1:0];
			quo_s[0] <= '0;
			ovf_s[0] <= CW'(top) >= CW'(den);
			pay_s[0] <= pay;
			for (int k = 1; k <= QW; k++) begin
				rem_s[k] <= ge[k-1] ? DW'(trial[k-1] - {1'b0, den}) : trial[k-1][DW-1:0];
				nlo_s[k] <= nlo_s[k-1] << 1;
				quo_s[k] <= (quo_s[k-1] << 1) | QW'(ge[k-1]);
				ovf_s[k] <= ovf_s[k-1];
				pay_s[k] <= pay_s[k-1];
			end
		end
	end

	assign q_vld = vld_s[QW];
	assign quot = quo_s[QW];
	assign ovf = ovf_s[QW];
	assign q_pay = pay_s[QW];

endmodule

// ===== hdl/gaussian_2d_model_jacobian.sv =====
// ----------------------------------------------------------------------------
// gaussian_2d_model_jacobian
// Gaussian model value and jacobian, when not stalled, for one pixel per clock
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while pix_stall is low and returns one
// result word per pixel, in order, through 3 setup stages, a 21 stage
// divider for r^2/(2 sigma^2), 7 stages for the exponential table and
// products, a 33 stage divider bank for the derivatives and the output
// register. The whole pipeline holds while a finished word waits on
// res_stall. Registers may be written only when no pixel is in flight.
module gaussian_2d_model_jacobian #(
	parameter int MAX_SIDE = g2j_pkg::MAX_SIDE_DEF,
	parameter int EXP_TABLE_DEPTH = g2j_pkg::EXP_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	output logic pix_stall,
	input g2j_pkg::pix_word_t pix,
	output logic res_valid,
	input logic res_stall,
	output g2j_pkg::res_word_t res,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [g2j_pkg::CFG_W-1:0] cfg_data
);

	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int L = $clog2(EXP_TABLE_DEPTH);
	localparam longint unsigned EXP_BASE = g2j_pkg::exp_base(L);
	localparam int CARW = $bits(g2j_pkg::car_t);

	// configuration
	logic [31:0] amplitude_q;
	logic [23:0] sigma_q;
	logic [31:0] background_q;
	logic [23:0] center_x_q;
	logic [23:0] center_y_q;
	logic [6:0] frame_side_q;
	logic [47:0] s2_q;
	logic [23:0] sg;
	logic [SW-1:0] side;
	logic aneg;

	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= g2j_pkg::AMPLITUDE_RST;
			sigma_q <= g2j_pkg::SIGMA_RST;
			background_q <= g2j_pkg::BACKGROUND_RST;
			center_x_q <= g2j_pkg::CENTER_RST;
			center_y_q <= g2j_pkg::CENTER_RST;
			frame_side_q <= g2j_pkg::FRAME_SIDE_RST;
		end else if (cfg_we) begin
			unique case (g2j_pkg::cfg_reg_t'(cfg_index))
				g2j_pkg::REG_AMPLITUDE: amplitude_q <= cfg_data;
				g2j_pkg::REG_SIGMA: sigma_q <= cfg_data[23:0];
				g2j_pkg::REG_BACKGROUND: background_q <= cfg_data;
				g2j_pkg::REG_CENTER_X: center_x_q <= cfg_data[23:0];
				g2j_pkg::REG_CENTER_Y: center_y_q <= cfg_data[23:0];
				g2j_pkg::REG_FRAME_SIDE: frame_side_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign sg = (sigma_q == '0) ? 24'd1 : sigma_q;
	assign side = (int'(frame_side_q) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(frame_side_q);
	assign aneg = amplitude_q[31];

	always_ff @(posedge clk)
		s2_q <= 48'(sg) * 48'(sg);

	// exponential table
	logic [16:0] exp_rom [EXP_TABLE_DEPTH+1];

	for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_rom
		assign exp_rom[g] = g2j_pkg::exp_entry(EXP_BASE, g);
	end

	// handshake
	logic res_vld_q;
	g2j_pkg::res_word_t res_q;

	assign en = !res_vld_q || !res_stall;
	assign pix_stall = !en;

	// stage 1: offsets from the centre
	logic signed [24:0] dx;
	logic signed [24:0] dy;
	g2j_pkg::car_t car0;

	always_comb begin
		dx = $signed({2'b00, 7'(pix.col) + 7'd1, 16'b0}) - 25'($signed(center_x_q));
		dy = $signed({2'b00, 7'(pix.row) + 7'd1, 16'b0}) - 25'($signed(center_y_q));
		car0 = '0;
		car0.idx = 12'(12'(pix.col) + 12'(pix.row) * 12'(side));
		car0.adx = dx[24] ? 24'(-dx) : 24'(dx);
		car0.ady = dy[24] ? 24'(-dy) : 24'(dy);
		car0.xneg = dx[24];
		car0.yneg = dy[24];
	end

	logic vld_s1, vld_s2, vld_s3;
	g2j_pkg::car_t car_s1, car_s2, car_s3;
	logic [47:0] sqx_s2, sqy_s2;
	logic [48:0] r2_s3;

	// after the first divider
	logic d1_vld;
	logic [19:0] d1_q;
	logic d1_ovf;
	logic [CARW-1:0] d1_pay;
	g2j_pkg::car_t d1_car;

	assign d1_car = g2j_pkg::car_t'(d1_pay);

	logic vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	g2j_pkg::car_t car_s4, car_s5, car_s6, car_s7, car_s8, car_s9, car_s10;
	logic [16:0] hi_s4, diff_s4, hi_s5;
	logic [19:0] frac_s4;
	logic far_s4, far_s5;
	logic [36:0] prod_s5;
	logic signed [49:0] pa_s7;
	logic signed [32:0] p_s8;
	logic [31:0] ap_s9;
	logic [52:0] ns_s10;
	logic [55:0] nx_s10, ny_s10;

	logic [19:0] t4;
	logic [L-1:0] ti;
	logic [37:0] rnd5;
	logic signed [49:0] pr7;
	logic signed [33:0] sum8;
	logic [31:0] model8;
	g2j_pkg::car_t car4_d, car6_d, car9_d;

	always_comb begin
		t4 = d1_ovf ? '0 : d1_q;
		ti = t4[19 -: L];
		car4_d = d1_car;
		car4_d.t = t4;
		rnd5 = 38'(prod_s5) + 38'(1 << 19);
		car6_d = car_s5;
		car6_d.e = far_s5 ? '0 : 17'(hi_s5 - 17'(rnd5 >> 20));
		pr7 = pa_s7 + 50'sd32768;
		sum8 = 34'(p_s8) + 34'($signed(background_q));
		if (sum8 > 34'sh0_7FFF_FFFF)
			model8 = 32'h7FFF_FFFF;
		else if (sum8 < -34'sh0_8000_0000)
			model8 = 32'h8000_0000;
		else
			model8 = 32'(sum8);
		car9_d = car_s8;
		car9_d.model = model8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pix_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= d1_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s1 <= car0;
			car_s2 <= car_s1;
			sqx_s2 <= 48'(car_s1.adx) * 48'(car_s1.adx);
			sqy_s2 <= 48'(car_s1.ady) * 48'(car_s1.ady);
			car_s3 <= car_s2;
			r2_s3 <= 49'(sqx_s2) + 49'(sqy_s2);
			// table lookup
			car_s4 <= car4_d;
			far_s4 <= d1_ovf;
			hi_s4 <= exp_rom[{1'b0, ti}];
			diff_s4 <= exp_rom[{1'b0, ti}] - exp_rom[(L+1)'(ti) + (L+1)'(1)];
			frac_s4 <= {t4[19-L:0], {L{1'b0}}};
			// interpolation
			car_s5 <= car_s4;
			far_s5 <= far_s4;
			hi_s5 <= hi_s4;
			prod_s5 <= 37'(diff_s4) * 37'(frac_s4);
			car_s6 <= car6_d;
			// amplitude scaling
			car_s7 <= car_s6;
			pa_s7 <= 50'($signed(amplitude_q)) * 50'($signed({1'b0, car_s6.e}));
			car_s8 <= car_s7;
			p_s8 <= 33'(pr7 >>> 16);
			car_s9 <= car9_d;
			ap_s9 <= p_s8[32] ? 32'(-p_s8) : 32'(p_s8);
			// numerators of the derivatives
			car_s10 <= car_s9;
			ns_s10 <= 53'(ap_s9) * 53'({car_s9.t, 1'b0});
			nx_s10 <= 56'(ap_s9) * 56'(car_s9.adx);
			ny_s10 <= 56'(ap_s9) * 56'(car_s9.ady);
		end
	end

	g2j_div #(
		.NW(64), .DW(48), .QW(20), .PW(CARW)
	) u_div_t (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(vld_s3),
		.num({r2_s3, 15'b0}), .den(s2_q), .pay(car_s3),
		.q_vld(d1_vld), .quot(d1_q), .ovf(d1_ovf), .q_pay(d1_pay)
	);

	logic ds_vld, dx_vld, dy_vld;
	logic [31:0] ds_q, dx_q, dy_q;
	logic ds_ovf, dx_ovf, dy_ovf;
	logic [CARW-1:0] ds_pay;
	logic dx_pay, dy_pay;
	g2j_pkg::car_t ds_car;

	assign ds_car = g2j_pkg::car_t'(ds_pay);

	g2j_div #(
		.NW(53), .DW(24), .QW(32), .PW(CARW)
	) u_div_s (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(vld_s10),
		.num(ns_s10), .den(sg), .pay(car_s10),
		.q_vld(ds_vld), .quot(ds_q), .ovf(ds_ovf), .q_pay(ds_pay)
	);

	g2j_div #(
		.NW(72), .DW(48), .QW(32), .PW(1)
	) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(vld_s10),
		.num({nx_s10, 16'b0}), .den(s2_q), .pay(aneg ^ car_s10.xneg),
		.q_vld(dx_vld), .quot(dx_q), .ovf(dx_ovf), .q_pay(dx_pay)
	);

	g2j_div #(
		.NW(72), .DW(48), .QW(32), .PW(1)
	) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(vld_s10),
		.num({ny_s10, 16'b0}), .den(s2_q), .pay(aneg ^ car_s10.yneg),
		.q_vld(dy_vld), .quot(dy_q), .ovf(dy_ovf), .q_pay(dy_pay)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_vld_q <= 1'b0;
		else if (en)
			res_vld_q <= ds_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.pixel_index <= ds_car.idx;
			res_q.model_value <= ds_car.model;
			res_q.d_amplitude <= ds_car.e;
			res_q.d_sigma <= g2j_pkg::sat_mag(aneg, ds_ovf, ds_q);
			res_q.d_background <= g2j_pkg::ONE_Q16;
			res_q.d_center_x <= g2j_pkg::sat_mag(dx_pay, dx_ovf, dx_q);
			res_q.d_center_y <= g2j_pkg::sat_mag(dy_pay, dy_ovf, dy_q);
		end
	end

	assign res_valid = res_vld_q;
	assign res = res_q;

	// checks
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		ds_vld == dx_vld && ds_vld == dy_vld)
		else $error("derivative dividers out of step");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid && res_stall)
		else $error("input held without a waiting word");

	a_gauss_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.d_amplitude <= g2j_pkg::ONE_Q16)
		else $error("gaussian factor above one");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(car_s10) && vld_s10 == $past(vld_s10))
		else $error("pipeline moved while stalled");

endmodule
